// File: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/csfd_pkg.sv
// Shared types and constants of the sensor frame decoder
`timescale 1ns / 1ps

package csfd_pkg;

    localparam int unsigned FRAME_BITS   = 40;
    localparam int unsigned BYTE_BITS    = 8;
    localparam int unsigned FRAME_BYTES  = FRAME_BITS / BYTE_BITS;
    localparam int unsigned CNT_W        = 6;
    localparam int unsigned BYTE_IDX_W   = 3;
    localparam int unsigned TIME_W       = 32;
    localparam int unsigned GAP_W        = 16;
    localparam int unsigned VALUE_W      = 16;
    localparam int unsigned PADDR_W      = 5;
    localparam int unsigned PDATA_W      = 32;
    localparam int unsigned S_TDATA_W    = 40;
    localparam int unsigned M_TDATA_W    = 80;
    localparam int unsigned M_TUSER_W    = 2;

    localparam logic [CNT_W-1:0] FRAME_BITS_C = CNT_W'(FRAME_BITS);

    // Byte positions within a frame
    localparam logic [BYTE_IDX_W-1:0] IDX_TYPE = 3'd0;
    localparam logic [BYTE_IDX_W-1:0] IDX_HIGH = 3'd1;
    localparam logic [BYTE_IDX_W-1:0] IDX_LOW  = 3'd2;
    localparam logic [BYTE_IDX_W-1:0] IDX_SUM  = 3'd3;
    localparam logic [BYTE_IDX_W-1:0] IDX_END  = 3'd4;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_GAP_LIMIT   = 3'd0,
        REG_END_MARKER  = 3'd1,
        REG_CO2_CODE    = 3'd2,
        REG_TEMP_CODE   = 3'd3,
        REG_HUMID_CODE  = 3'd4
    } reg_idx_t;

    localparam logic [GAP_W-1:0] GAP_LIMIT_RST  = 16'd2;
    localparam logic [7:0]       END_MARKER_RST = 8'd13;
    localparam logic [7:0]       CO2_CODE_RST   = 8'd80;
    localparam logic [7:0]       TEMP_CODE_RST  = 8'd66;
    localparam logic [7:0]       HUMID_CODE_RST = 8'd65;

    typedef struct packed {
        logic [GAP_W-1:0] gap_limit_ms;
        logic [7:0]       end_marker;
        logic [7:0]       co2_code;
        logic [7:0]       temperature_code;
        logic [7:0]       humidity_code;
    } cfg_t;

    typedef struct packed {
        logic               frame_ok;
        logic               frame_bad;
        logic [7:0]         frame_type;
        logic [VALUE_W-1:0] frame_value;
        logic [VALUE_W-1:0] co2_level;
        logic [VALUE_W-1:0] temperature_level;
        logic [VALUE_W-1:0] humidity_level;
        logic [CNT_W-1:0]   bits_held;
    } result_t;

endpackage

// File: rtl/clocked_sensor_frame_decoder_top.sv
// Top level of the clocked sensor frame decoder
`timescale 1ns / 1ps

// Decodes a five-byte sensor frame (type, value high, value low, sum, end) sent
// one bit per sensor clock edge, MSB first. Each input item is one edge with its
// millisecond timestamp; a gap above gap_limit_ms restarts the frame. Every item
// gives exactly one result item carrying the check flags, the last good frame
// and the three level stores. A result reaches the output register from the input
// register that holds its input item; one item is taken every cycle while the output
// is not stalled, set by the update of the frame state between the two registers.
// Output back-pressure stalls the input side once both registers are full.

module clocked_sensor_frame_decoder_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB-style configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csfd_pkg::PADDR_W-1:0]        paddr,
    input  logic [csfd_pkg::PDATA_W-1:0]        pwdata,
    output logic [csfd_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [csfd_pkg::S_TDATA_W-1:0]      s_tdata,   // time_ms[31:0], data_level[32], zero pad
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [csfd_pkg::M_TDATA_W-1:0]      m_tdata,   // frame_type, frame_value, co2_level,
                                                           // temperature_level, humidity_level,
                                                           // bits_held, zero pad
    output logic [csfd_pkg::M_TUSER_W-1:0]      m_tuser    // frame_ok, frame_bad
);

    csfd_pkg::cfg_t                 cfg;
    csfd_pkg::result_t              result;
    csfd_pkg::result_t              out_reg;
    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [csfd_pkg::TIME_W-1:0]    in_time_reg;
    logic                           in_bit_reg;
    logic                           s_accept;
    logic                           advance;

    csfd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Item moves from the input register into the output register
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance  ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_time_reg <= s_tdata[csfd_pkg::TIME_W-1:0];
            in_bit_reg  <= s_tdata[csfd_pkg::TIME_W];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    csfd_frame_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .time_ms    (in_time_reg),
        .data_level (in_bit_reg),
        .cfg        (cfg),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.frame_bad, out_reg.frame_ok};
    assign m_tdata  = {2'b00,
                       out_reg.bits_held,
                       out_reg.humidity_level,
                       out_reg.temperature_level,
                       out_reg.co2_level,
                       out_reg.frame_value,
                       out_reg.frame_type};

endmodule

// File: rtl/csfd_cfg_regs.sv
// Configuration register file with APB-style access
`timescale 1ns / 1ps

module csfd_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csfd_pkg::PADDR_W-1:0]    paddr,
    input  logic [csfd_pkg::PDATA_W-1:0]    pwdata,
    output logic [csfd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output csfd_pkg::cfg_t                  cfg
);

    csfd_pkg::cfg_t     cfg_reg;
    csfd_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign reg_idx = csfd_pkg::reg_idx_t'(paddr[csfd_pkg::PADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_limit_ms     <= csfd_pkg::GAP_LIMIT_RST;
            cfg_reg.end_marker       <= csfd_pkg::END_MARKER_RST;
            cfg_reg.co2_code         <= csfd_pkg::CO2_CODE_RST;
            cfg_reg.temperature_code <= csfd_pkg::TEMP_CODE_RST;
            cfg_reg.humidity_code    <= csfd_pkg::HUMID_CODE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                csfd_pkg::REG_GAP_LIMIT:
                    cfg_reg.gap_limit_ms <= pwdata[csfd_pkg::GAP_W-1:0];
                csfd_pkg::REG_END_MARKER:
                    cfg_reg.end_marker <= pwdata[7:0];
                csfd_pkg::REG_CO2_CODE:
                    cfg_reg.co2_code <= pwdata[7:0];
                csfd_pkg::REG_TEMP_CODE:
                    cfg_reg.temperature_code <= pwdata[7:0];
                csfd_pkg::REG_HUMID_CODE:
                    cfg_reg.humidity_code <= pwdata[7:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            csfd_pkg::REG_GAP_LIMIT:
                prdata = {16'd0, cfg_reg.gap_limit_ms};
            csfd_pkg::REG_END_MARKER:
                prdata = {24'd0, cfg_reg.end_marker};
            csfd_pkg::REG_CO2_CODE:
                prdata = {24'd0, cfg_reg.co2_code};
            csfd_pkg::REG_TEMP_CODE:
                prdata = {24'd0, cfg_reg.temperature_code};
            csfd_pkg::REG_HUMID_CODE:
                prdata = {24'd0, cfg_reg.humidity_code};
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: rtl/csfd_frame_core.sv
// Frame state: gap detection, bit shifting, frame checks and level stores
`timescale 1ns / 1ps

module csfd_frame_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [csfd_pkg::TIME_W-1:0]     time_ms,
    input  logic                            data_level,
    input  csfd_pkg::cfg_t                  cfg,
    output csfd_pkg::result_t               result
);

    logic [csfd_pkg::TIME_W-1:0]    last_edge_time_reg;
    logic [csfd_pkg::CNT_W-1:0]     bit_counter_reg;
    logic [csfd_pkg::CNT_W-1:0]     bit_counter_next;
    logic [7:0]                     frame_bytes_reg  [csfd_pkg::FRAME_BYTES];
    logic [7:0]                     frame_bytes_next [csfd_pkg::FRAME_BYTES];
    logic [7:0]                     last_type_reg;
    logic [7:0]                     last_type_next;
    logic [csfd_pkg::VALUE_W-1:0]   last_value_reg;
    logic [csfd_pkg::VALUE_W-1:0]   last_value_next;
    logic [csfd_pkg::VALUE_W-1:0]   co2_store_reg;
    logic [csfd_pkg::VALUE_W-1:0]   co2_store_next;
    logic [csfd_pkg::VALUE_W-1:0]   temp_store_reg;
    logic [csfd_pkg::VALUE_W-1:0]   temp_store_next;
    logic [csfd_pkg::VALUE_W-1:0]   humid_store_reg;
    logic [csfd_pkg::VALUE_W-1:0]   humid_store_next;

    logic [csfd_pkg::TIME_W-1:0]    gap;
    logic                           restart;
    logic [csfd_pkg::CNT_W-1:0]     cnt_base;
    logic                           collect;
    logic [csfd_pkg::BYTE_IDX_W-1:0] byte_idx;
    logic                           complete;
    logic [7:0]                     sum;
    logic                           pass;
    logic                           ok;
    logic                           bad;
    logic [7:0]                     ftype;
    logic [csfd_pkg::VALUE_W-1:0]   fvalue;

    // Wrapping difference; a gap equal to the limit keeps the frame going
    assign gap      = time_ms - last_edge_time_reg;
    assign restart  = gap > {{(csfd_pkg::TIME_W-csfd_pkg::GAP_W){1'b0}}, cfg.gap_limit_ms};
    assign cnt_base = restart ? '0 : bit_counter_reg;
    assign collect  = cnt_base < csfd_pkg::FRAME_BITS_C;
    assign byte_idx = cnt_base[csfd_pkg::CNT_W-1:3];

    always_comb
    begin
        for (int i = 0; i < csfd_pkg::FRAME_BYTES; i++)
        begin
            if (collect && byte_idx == csfd_pkg::BYTE_IDX_W'(i))
                frame_bytes_next[i] = {frame_bytes_reg[i][6:0], data_level};
            else
                frame_bytes_next[i] = frame_bytes_reg[i];
        end
    end

    assign bit_counter_next = collect ? cnt_base + 1'b1 : cnt_base;
    assign complete = collect && (bit_counter_next == csfd_pkg::FRAME_BITS_C);

    assign sum    = frame_bytes_next[csfd_pkg::IDX_TYPE] + frame_bytes_next[csfd_pkg::IDX_HIGH]
                  + frame_bytes_next[csfd_pkg::IDX_LOW];
    assign pass   = (sum == frame_bytes_next[csfd_pkg::IDX_SUM])
                  && (frame_bytes_next[csfd_pkg::IDX_END] == cfg.end_marker);
    assign ok     = complete & pass;
    assign bad    = complete & ~pass;
    assign ftype  = frame_bytes_next[csfd_pkg::IDX_TYPE];
    assign fvalue = {frame_bytes_next[csfd_pkg::IDX_HIGH], frame_bytes_next[csfd_pkg::IDX_LOW]};

    // Overlapping codes load every matching store
    assign last_type_next   = ok ? ftype  : last_type_reg;
    assign last_value_next  = ok ? fvalue : last_value_reg;
    assign co2_store_next   = (ok && ftype == cfg.co2_code)         ? fvalue : co2_store_reg;
    assign temp_store_next  = (ok && ftype == cfg.temperature_code) ? fvalue : temp_store_reg;
    assign humid_store_next = (ok && ftype == cfg.humidity_code)    ? fvalue : humid_store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_time_reg <= '0;
            bit_counter_reg    <= '0;
            for (int i = 0; i < csfd_pkg::FRAME_BYTES; i++)
            begin
                frame_bytes_reg[i] <= '0;
            end
            last_type_reg      <= '0;
            last_value_reg     <= '0;
            co2_store_reg      <= '0;
            temp_store_reg     <= '0;
            humid_store_reg    <= '0;
        end
        else if (en)
        begin
            last_edge_time_reg <= time_ms;
            bit_counter_reg    <= bit_counter_next;
            for (int i = 0; i < csfd_pkg::FRAME_BYTES; i++)
            begin
                frame_bytes_reg[i] <= frame_bytes_next[i];
            end
            last_type_reg      <= last_type_next;
            last_value_reg     <= last_value_next;
            co2_store_reg      <= co2_store_next;
            temp_store_reg     <= temp_store_next;
            humid_store_reg    <= humid_store_next;
        end
    end

    always_comb
    begin
        result.frame_ok          = ok;
        result.frame_bad         = bad;
        result.frame_type        = last_type_next;
        result.frame_value       = last_value_next;
        result.co2_level         = co2_store_next;
        result.temperature_level = temp_store_next;
        result.humidity_level    = humid_store_next;
        result.bits_held         = bit_counter_next;
    end

endmodule

// File: rtl/csfd_checker.sv
// Port-level checks on the result stream of the frame decoder
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csfd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [csfd_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic [csfd_pkg::M_TUSER_W-1:0]      m_tuser
);

    logic [csfd_pkg::CNT_W-1:0] bits_held;
    logic                       done;

    assign bits_held = m_tdata[77:72];
    assign done      = m_tuser[0] | m_tuser[1];

    // A completed frame is either good or bad, never both
    `ASSERT_IMPLIES(a_ok_bad_excl, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]))
    // Counter never passes a full frame
    `ASSERT_IMPLIES(a_bits_range, clk, rst_n, m_tvalid, bits_held <= csfd_pkg::FRAME_BITS_C)
    // A check result only appears on the item that filled the frame
    `ASSERT_IMPLIES(a_done_full, clk, rst_n, m_tvalid && done, bits_held == csfd_pkg::FRAME_BITS_C)
    // Stalled result stays put
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind clocked_sensor_frame_decoder_top csfd_checker u_csfd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/tb_clocked_sensor_frame_decoder_top.sv
// Testbench for the clocked sensor frame decoder: random edge streams checked against a predictor
`timescale 1ns / 1ps

module tb_clocked_sensor_frame_decoder_top;

    // Predicts one result item per sensor edge and checks what the block returns
    class sensor_frame_predictor;
        csfd_pkg::cfg_t     cfg;
        logic [31:0]        last_edge;
        logic [5:0]         bit_cnt;
        logic [7:0]         frame_buf [csfd_pkg::FRAME_BYTES];
        logic [7:0]         last_type;
        logic [15:0]        last_value;
        logic [15:0]        co2_store;
        logic [15:0]        temp_store;
        logic [15:0]        humid_store;
        csfd_pkg::result_t  expected_results [$];
        int                 errors;

        function new();
            cfg.gap_limit_ms     = csfd_pkg::GAP_LIMIT_RST;
            cfg.end_marker       = csfd_pkg::END_MARKER_RST;
            cfg.co2_code         = csfd_pkg::CO2_CODE_RST;
            cfg.temperature_code = csfd_pkg::TEMP_CODE_RST;
            cfg.humidity_code    = csfd_pkg::HUMID_CODE_RST;
            last_edge   = '0;
            bit_cnt     = '0;
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            last_type   = '0;
            last_value  = '0;
            co2_store   = '0;
            temp_store  = '0;
            humid_store = '0;
            errors      = 0;
        endfunction

        function void set_reg(csfd_pkg::reg_idx_t idx, logic [31:0] v);
            case (idx)
                csfd_pkg::REG_GAP_LIMIT:  cfg.gap_limit_ms     = v[15:0];
                csfd_pkg::REG_END_MARKER: cfg.end_marker       = v[7:0];
                csfd_pkg::REG_CO2_CODE:   cfg.co2_code         = v[7:0];
                csfd_pkg::REG_TEMP_CODE:  cfg.temperature_code = v[7:0];
                csfd_pkg::REG_HUMID_CODE: cfg.humidity_code    = v[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void take_edge(logic [31:0] t, logic b);
            logic [31:0]        elapsed;
            logic [7:0]         sum8;
            logic [15:0]        val;
            csfd_pkg::result_t  r;
            elapsed = t - last_edge;
            if (elapsed > 32'(cfg.gap_limit_ms))
                bit_cnt = '0;
            last_edge = t;
            r = '0;
            if (bit_cnt < csfd_pkg::FRAME_BITS_C)
            begin
                frame_buf[bit_cnt / csfd_pkg::BYTE_BITS] =
                    {frame_buf[bit_cnt / csfd_pkg::BYTE_BITS][6:0], b};
                bit_cnt = bit_cnt + 6'd1;
                if (bit_cnt == csfd_pkg::FRAME_BITS_C)
                begin
                    sum8 = frame_buf[csfd_pkg::IDX_TYPE] + frame_buf[csfd_pkg::IDX_HIGH]
                         + frame_buf[csfd_pkg::IDX_LOW];
                    if (sum8 == frame_buf[csfd_pkg::IDX_SUM]
                        && frame_buf[csfd_pkg::IDX_END] == cfg.end_marker)
                    begin
                        val = {frame_buf[csfd_pkg::IDX_HIGH], frame_buf[csfd_pkg::IDX_LOW]};
                        r.frame_ok = 1'b1;
                        last_type  = frame_buf[csfd_pkg::IDX_TYPE];
                        last_value = val;
                        // several codes may be equal, so each is tested on its own
                        if (last_type == cfg.humidity_code)
                            humid_store = val;
                        if (last_type == cfg.temperature_code)
                            temp_store = val;
                        if (last_type == cfg.co2_code)
                            co2_store = val;
                    end
                    else
                    begin
                        r.frame_bad = 1'b1;
                    end
                end
            end
            r.frame_type        = last_type;
            r.frame_value       = last_value;
            r.co2_level         = co2_store;
            r.temperature_level = temp_store;
            r.humidity_level    = humid_store;
            r.bits_held         = bit_cnt;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(logic [csfd_pkg::M_TDATA_W-1:0] tdata,
                                   logic [csfd_pkg::M_TUSER_W-1:0] tuser);
            csfd_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result item with nothing expected, actual %0h/%0h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("frame_ok",          want.frame_ok,          tuser[0]);
            compare_field("frame_bad",         want.frame_bad,         tuser[1]);
            compare_field("frame_type",        want.frame_type,        tdata[7:0]);
            compare_field("frame_value",       want.frame_value,       tdata[23:8]);
            compare_field("co2_level",         want.co2_level,         tdata[39:24]);
            compare_field("temperature_level", want.temperature_level, tdata[55:40]);
            compare_field("humidity_level",    want.humidity_level,    tdata[71:56]);
            compare_field("bits_held",         want.bits_held,         tdata[77:72]);
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [csfd_pkg::PADDR_W-1:0]   paddr;
    logic [csfd_pkg::PDATA_W-1:0]   pwdata;
    logic [csfd_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [csfd_pkg::S_TDATA_W-1:0] s_tdata;    // time_ms[31:0], data_level[32], zero pad
    logic                           m_tvalid;
    logic                           m_tready;
    logic [csfd_pkg::M_TDATA_W-1:0] m_tdata;    // frame_type, frame_value, co2_level,
                                                // temperature_level, humidity_level, bits_held
    logic [csfd_pkg::M_TUSER_W-1:0] m_tuser;    // frame_ok, frame_bad

    sensor_frame_predictor predictor;
    logic [31:0]  sensor_time;
    int unsigned  items_sent;
    int unsigned  burst_left;
    int unsigned  rx_left;
    int unsigned  rx_mode;

    clocked_sensor_frame_decoder_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver: stretches of always ready, coin-toss ready and mostly stalled
    initial
    begin
        m_tready = 1'b0;
        rx_left  = 0;
        rx_mode  = 0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            predictor.check_result(m_tdata, m_tuser);
    end

    task automatic send_edge(input logic [31:0] t, input logic b);
        int unsigned pause;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 40);
            pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (pause > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (pause) @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, b, t};
        do
            @(posedge clk);
        while (!s_tready);
        predictor.take_edge(t, b);
        items_sent++;
        burst_left--;
    endtask

    // Stop sending and let every result drain, plus the output latency
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predictor.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input csfd_pkg::reg_idx_t idx, input logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        predictor.set_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] gap, input logic [31:0] endm,
                                input logic [31:0] co2, input logic [31:0] temp,
                                input logic [31:0] humid);
        drain_results();
        write_reg(csfd_pkg::REG_GAP_LIMIT,  gap);
        write_reg(csfd_pkg::REG_END_MARKER, endm);
        write_reg(csfd_pkg::REG_CO2_CODE,   co2);
        write_reg(csfd_pkg::REG_TEMP_CODE,  temp);
        write_reg(csfd_pkg::REG_HUMID_CODE, humid);
    endtask

    // Sends the first nbits of a frame MSB first after a restarting gap.
    // exact: every following edge lands exactly on the gap limit.
    task automatic send_frame(input logic [39:0] word, input int nbits, input bit exact);
        logic [31:0] lim;
        lim = 32'(predictor.cfg.gap_limit_ms);
        sensor_time = sensor_time + lim + 32'd1 + $urandom_range(0, 300);
        for (int i = 0; i < nbits; i++)
        begin
            if (i > 0)
                sensor_time = sensor_time + (exact ? lim : $urandom_range(0, lim));
            send_edge(sensor_time, word[39 - i]);
        end
    endtask

    // Edges within the gap limit, beyond the end of a frame
    task automatic send_trailing(input int n);
        logic [31:0] lim;
        lim = 32'(predictor.cfg.gap_limit_ms);
        repeat (n)
        begin
            sensor_time = sensor_time + $urandom_range(0, lim);
            send_edge(sensor_time, $urandom_range(0, 1));
        end
    endtask

    function automatic logic [39:0] good_frame(logic [7:0] ty, logic [15:0] val,
                                               logic [7:0] tail);
        logic [7:0] s;
        s = ty + val[15:8] + val[7:0];
        return {ty, val, s, tail};
    endfunction

    task automatic random_action();
        logic [7:0]  ty;
        logic [15:0] val;
        logic [39:0] word;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       ty = predictor.cfg.co2_code;
            1:       ty = predictor.cfg.temperature_code;
            2:       ty = predictor.cfg.humidity_code;
            default: ty = $urandom;
        endcase
        val  = $urandom;
        word = good_frame(ty, val, predictor.cfg.end_marker);
        if (pick < 70)
        begin
            case ($urandom_range(0, 7))
                0:       word[15:8] = word[15:8] ^ 8'($urandom_range(1, 255));
                1:       word[7:0]  = word[7:0] ^ 8'($urandom_range(1, 255));
                default: ;
            endcase
            send_frame(word, csfd_pkg::FRAME_BITS, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0)
                send_trailing($urandom_range(1, 6));
        end
        else if (pick < 85)
        begin
            // broken frame: cut short, the next restart discards it
            send_frame(word, $urandom_range(1, csfd_pkg::FRAME_BITS - 1), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                sensor_time = $urandom;
                send_edge(sensor_time, $urandom_range(0, 1));
            end
        end
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned start;
        start = items_sent;
        while (items_sent - start < quota)
            random_action();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        sensor_time = '0;
        items_sent  = 0;
        burst_left  = 0;
        predictor   = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: one frame per level register, extremes of the value
        send_frame(good_frame(8'd80, 16'hFFFF, 8'd13), csfd_pkg::FRAME_BITS, 1'b0);
        send_frame(good_frame(8'd66, 16'h0000, 8'd13), csfd_pkg::FRAME_BITS, 1'b1);
        send_frame(good_frame(8'd65, 16'h8001, 8'd13), csfd_pkg::FRAME_BITS, 1'b0);
        // wrong sum, wrong end byte, then a type that matches no register
        send_frame({8'd80, 16'h1234, 8'h00, 8'd13}, csfd_pkg::FRAME_BITS, 1'b0);
        send_frame({good_frame(8'd66, 16'h5AA5, 8'd12)}, csfd_pkg::FRAME_BITS, 1'b0);
        send_frame(good_frame(8'hFF, 16'h7FFE, 8'd13), csfd_pkg::FRAME_BITS, 1'b0);
        send_trailing(5);
        // cut short by a gap, then a full frame that wraps the timestamp
        send_frame(good_frame(8'd65, 16'h0F0F, 8'd13), 17, 1'b0);
        sensor_time = 32'hFFFF_FFF0;
        send_frame(good_frame(8'd65, 16'hC3C3, 8'd13), csfd_pkg::FRAME_BITS, 1'b0);

        // all codes equal, zero gap limit, zero end byte
        apply_config(32'd0, 32'd0, 32'h33, 32'h33, 32'h33);
        send_frame(good_frame(8'h33, 16'hBEEF, 8'h00), csfd_pkg::FRAME_BITS, 1'b1);
        send_frame(good_frame(8'h33, 16'h0001, 8'h00), 9, 1'b1);

        apply_config(32'hFFFF_FFFF, 32'd255, 32'd0, 32'd255, 32'd128);
        send_frame(good_frame(8'd0, 16'hA5A5, 8'd255), csfd_pkg::FRAME_BITS, 1'b1);
        send_frame(good_frame(8'd255, 16'h5A5A, 8'd255), csfd_pkg::FRAME_BITS, 1'b0);
        send_frame(good_frame(8'd128, 16'hFFFF, 8'd255), csfd_pkg::FRAME_BITS, 1'b0);

        apply_config($urandom_range(1, 20), $urandom, $urandom, $urandom, $urandom);
        random_phase(260);
        apply_config(32'd65535, 32'd0, 32'd255, 32'd255, 32'd0);
        random_phase(260);
        apply_config(32'd0, 32'd255, $urandom, $urandom, $urandom);
        random_phase(200);
        apply_config($urandom_range(0, 1000), $urandom, $urandom, $urandom, $urandom);
        random_phase(260);

        drain_results();
        repeat (10) @(posedge clk);
        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
